FILE: rtl/hlbbc_pkg.sv
package hlbbc_pkg;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_APPLY = 2'd2,
    FSM_OUT   = 2'd3
  } fsm_e;

  localparam int unsigned IdxW   = 5;
  localparam int unsigned RefsW  = 8;
  localparam logic [7:0]  RefsMax = 8'hff;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic [4:0] entry_index;
    logic       hit;
    logic       needs_fill;
    logic [1:0] status;
  } rsp_t;

  // Search token that ripples down the cell chain.
  typedef struct packed {
    logic        hit_found;
    logic [IdxW-1:0] hit_idx;
    logic        bkt_found;
    logic [IdxW-1:0] bkt_idx;
    logic [31:0] bkt_stamp;
    logic        any_found;
    logic [IdxW-1:0] any_idx;
    logic [31:0] any_stamp;
  } tok_t;

  // Command broadcast to all cells in the apply cycle.
  typedef struct packed {
    logic        en;
    logic        retag;
    logic        inc;
    logic        dec;
    logic        stamp;
    logic [IdxW-1:0] idx;
  } cmd_t;

endpackage

FILE: rtl/hlbbc_cell.sv
module hlbbc_cell #(
  parameter int unsigned MyIdx   = 0,
  parameter int unsigned BktW    = 3,
  parameter int unsigned InitBkt = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              scan_i,
  input  logic [7:0]        dev_i,
  input  logic [31:0]       blk_i,
  input  logic [BktW-1:0]   bkt_i,
  input  logic [31:0]       now_i,
  input  hlbbc_pkg::tok_t   tok_i,
  output hlbbc_pkg::tok_t   tok_o,
  input  hlbbc_pkg::cmd_t   cmd_i,
  output logic [7:0]        refs_o,
  output logic              valid_o
);

  logic [7:0]      dev_q;
  logic [31:0]     blk_q;
  logic [BktW-1:0] bkt_q;
  logic            valid_q;
  logic [7:0]      refs_q;
  logic [31:0]     stamp_q;
  logic            sel, free, in_bkt;

  assign sel    = cmd_i.en && (cmd_i.idx == hlbbc_pkg::IdxW'(MyIdx));
  assign free   = (refs_q == '0);
  assign in_bkt = (bkt_q == bkt_i);
  assign refs_o  = refs_q;
  assign valid_o = valid_q;

  // Token update: first hit wins, strict-less keeps the lowest index on ties.
  always_comb begin
    tok_o = tok_i;
    if (scan_i) begin
      if (!tok_i.hit_found && in_bkt && dev_q == dev_i && blk_q == blk_i) begin
        tok_o.hit_found = 1'b1;
        tok_o.hit_idx   = hlbbc_pkg::IdxW'(MyIdx);
      end
      if (free && in_bkt && (!tok_i.bkt_found || stamp_q < tok_i.bkt_stamp)) begin
        tok_o.bkt_found = 1'b1;
        tok_o.bkt_idx   = hlbbc_pkg::IdxW'(MyIdx);
        tok_o.bkt_stamp = stamp_q;
      end
      if (free && (!tok_i.any_found || stamp_q < tok_i.any_stamp)) begin
        tok_o.any_found = 1'b1;
        tok_o.any_idx   = hlbbc_pkg::IdxW'(MyIdx);
        tok_o.any_stamp = stamp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= '0;
      blk_q   <= '0;
      bkt_q   <= BktW'(InitBkt);
      valid_q <= 1'b0;
      refs_q  <= '0;
      stamp_q <= '0;
    end else if (sel) begin
      if (cmd_i.retag) begin
        dev_q   <= dev_i;
        blk_q   <= blk_i;
        bkt_q   <= bkt_i;
        valid_q <= 1'b1;
        refs_q  <= 8'd1;
      end else if (cmd_i.inc) begin
        valid_q <= valid_q | (cmd_i.stamp);
        if (refs_q != hlbbc_pkg::RefsMax) refs_q <= refs_q + 8'd1;
      end else if (cmd_i.dec && !free) begin
        refs_q <= refs_q - 8'd1;
        if (cmd_i.stamp && refs_q == 8'd1) stamp_q <= now_i;
      end
    end
  end

endmodule

FILE: rtl/hashed_lru_block_buffer_cache.sv
// Channel | Direction | Handshake               | Word
// req     | in        | req_valid_i/req_stall_o | hlbbc_pkg::req_t
// rsp     | out       | rsp_valid_o/rsp_stall_i | hlbbc_pkg::rsp_t
//
// A word is taken only in idle. Scan: the search token crosses one group of
// 8 cells per cycle and is registered between groups. Apply: the chosen cell
// updates. The result is offered from the next cycle on. Reset is
// asynchronous and puts every descriptor in its power-on state. A stalled
// result holds; the request side stalls until it is taken.
module hashed_lru_block_buffer_cache #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  hlbbc_pkg::req_t  req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output hlbbc_pkg::rsp_t  rsp_o
);

  localparam int unsigned PerBucket = NUM_BUFFERS / NUM_BUCKETS;
  localparam int unsigned BktW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  // cells per scan cycle
  localparam int unsigned SegLen = 8;
  localparam int unsigned NumSeg = (NUM_BUFFERS + SegLen - 1) / SegLen;
  localparam int unsigned CntW = (NumSeg > 1) ? $clog2(NumSeg) : 1;

  hlbbc_pkg::fsm_e  state_q, state_d;
  hlbbc_pkg::req_t  req_q;
  hlbbc_pkg::tok_t  tok [NUM_BUFFERS+1];
  hlbbc_pkg::tok_t  tok_q;
  hlbbc_pkg::cmd_t  cmd;
  hlbbc_pkg::rsp_t  rsp_q, rsp_d;
  logic [7:0]       refs [NUM_BUFFERS];
  logic             valid [NUM_BUFFERS];
  logic [BktW-1:0]  bkt;
  logic             in_range;
  logic [hlbbc_pkg::IdxW-1:0] tgt;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             scan_last;

  // bucket = block mod bucket count
  if (NUM_BUCKETS == 1) begin : g_bkt_one
    assign bkt = '0;
  end else if ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0) begin : g_bkt_mask
    assign bkt = req_q.block_number[BktW-1:0];
  end else begin : g_bkt_mod
    assign bkt = BktW'(req_q.block_number % NUM_BUCKETS);
  end

  assign in_range = {27'd0, req_q.buffer_index} < 32'(NUM_BUFFERS);
  assign tok[0] = '0;

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    hlbbc_pkg::tok_t tok_in;

    // Group boundary: token registered, the next group reads the registered copy.
    if ((g % SegLen) == 0 && g != 0) begin : g_bnd
      hlbbc_pkg::tok_t bnd_q;
      always_ff @(posedge clk_i) begin
        if (state_q == hlbbc_pkg::FSM_SCAN) bnd_q <= tok[g];
      end
      assign tok_in = bnd_q;
    end else begin : g_link
      assign tok_in = tok[g];
    end

    hlbbc_cell #(
      .MyIdx  (g),
      .BktW   (BktW),
      .InitBkt((g / PerBucket) % NUM_BUCKETS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scan_i (state_q == hlbbc_pkg::FSM_SCAN),
      .dev_i  (req_q.device),
      .blk_i  (req_q.block_number),
      .bkt_i  (bkt),
      .now_i  (req_q.current_time),
      .tok_i  (tok_in),
      .tok_o  (tok[g+1]),
      .cmd_i  (cmd),
      .refs_o (refs[g]),
      .valid_o(valid[g])
    );
  end

  assign req_stall_o = (state_q != hlbbc_pkg::FSM_IDLE);
  assign rsp_valid_o = (state_q == hlbbc_pkg::FSM_OUT);
  assign rsp_o       = rsp_q;

  // scan cycle count, one per cell group
  assign scan_last = (scan_q == CntW'(NumSeg - 1));
  assign scan_d    = (state_q == hlbbc_pkg::FSM_SCAN && !scan_last) ? scan_q + 1'b1 : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hlbbc_pkg::FSM_IDLE:  if (req_valid_i) state_d = hlbbc_pkg::FSM_SCAN;
      hlbbc_pkg::FSM_SCAN:  if (scan_last) state_d = hlbbc_pkg::FSM_APPLY;
      hlbbc_pkg::FSM_APPLY: state_d = hlbbc_pkg::FSM_OUT;
      hlbbc_pkg::FSM_OUT:   if (!rsp_stall_i) state_d = hlbbc_pkg::FSM_IDLE;
      default:              state_d = hlbbc_pkg::FSM_IDLE;
    endcase
  end

  // Decision in the apply cycle from the registered token.
  always_comb begin
    cmd   = '0;
    rsp_d = rsp_q;
    tgt   = '0;
    if (state_q == hlbbc_pkg::FSM_APPLY) begin
      rsp_d = '0;
      if (req_q.action == hlbbc_pkg::ACT_GET) begin
        if (tok_q.hit_found) begin
          tgt = tok_q.hit_idx;
          cmd.en = 1'b1; cmd.inc = 1'b1; cmd.stamp = 1'b1; cmd.idx = tgt;
          rsp_d.hit = 1'b1;
          rsp_d.needs_fill = !valid[tgt];
          rsp_d.entry_index = tgt;
        end else if (tok_q.bkt_found || tok_q.any_found) begin
          tgt = tok_q.bkt_found ? tok_q.bkt_idx : tok_q.any_idx;
          cmd.en = 1'b1; cmd.retag = 1'b1; cmd.idx = tgt;
          rsp_d.needs_fill = 1'b1;
          rsp_d.entry_index = tgt;
        end else begin
          rsp_d.status = hlbbc_pkg::ST_NO_FREE;
        end
      end else begin
        tgt = req_q.buffer_index;
        rsp_d.entry_index = req_q.buffer_index;
        if (in_range) begin
          cmd.en = 1'b1; cmd.idx = tgt;
          if (req_q.action == hlbbc_pkg::ACT_PIN) begin
            cmd.inc = 1'b1;
          end else begin
            cmd.dec = 1'b1;
            cmd.stamp = (req_q.action == hlbbc_pkg::ACT_RELEASE);
            if (refs[tgt] == '0) rsp_d.status = hlbbc_pkg::ST_UNDERFLOW;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlbbc_pkg::FSM_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hlbbc_pkg::FSM_IDLE && req_valid_i) req_q <= req_i;
    if (state_q == hlbbc_pkg::FSM_SCAN) tok_q <= tok[NUM_BUFFERS];
    rsp_q <= rsp_d;
  end

endmodule

FILE: rtl/hlbbc_checker.sv
module hlbbc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_stall_o,
  input hlbbc_pkg::rsp_t rsp_o,
  input logic            rsp_valid_o,
  input logic            rsp_stall_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o)) else $error("rsp moved");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("accept during result");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o && !rsp_valid_o) else $error("accept");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != hlbbc_pkg::ST_OK |-> !rsp_o.hit && !rsp_o.needs_fill)
    else $error("status flags");

endmodule

bind hashed_lru_block_buffer_cache hlbbc_checker u_hlbbc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i),
  .req_stall_o(req_stall_o), .rsp_o(rsp_o), .rsp_valid_o(rsp_valid_o),
  .rsp_stall_i(rsp_stall_i)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int NBUF = 32;
  localparam int NBKT = 8;
  localparam int PER_BKT = NBUF / NBKT;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  hlbbc_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  hlbbc_pkg::rsp_t rsp_o;

  hashed_lru_block_buffer_cache uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_stall_o(req_stall_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_stall_i(rsp_stall_i), .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scoreboard: shadow descriptor pool plus a queue of predicted result words.
  class cache_scoreboard;
    logic [7:0]  dev_q[NBUF];
    logic [31:0] blk_q[NBUF];
    logic [2:0]  bkt_q[NBUF];
    logic        vld_q[NBUF];
    logic [7:0]  refs_q[NBUF];
    logic [31:0] stamp_q[NBUF];
    hlbbc_pkg::rsp_t pending_rsp[$];
    int          mismatches;

    function new();
      mismatches = 0;
      for (int i = 0; i < NBUF; i++) begin
        dev_q[i] = '0; blk_q[i] = '0; bkt_q[i] = 3'(i / PER_BKT);
        vld_q[i] = 1'b0; refs_q[i] = '0; stamp_q[i] = '0;
      end
    endfunction

    // Oldest free entry, lowest index on equal stamps; -1 if none.
    function int oldest_free(bit only_bkt, logic [2:0] bkt);
      int best;
      best = -1;
      for (int i = 0; i < NBUF; i++) begin
        if (only_bkt && bkt_q[i] != bkt) continue;
        if (refs_q[i] != 0) continue;
        if (best < 0 || stamp_q[i] < stamp_q[best]) best = i;
      end
      return best;
    endfunction

    function void note_word(hlbbc_pkg::req_t w);
      hlbbc_pkg::rsp_t r;
      logic [2:0] bkt;
      int found;
      int v;
      r = '0;
      found = -1;
      if (hlbbc_pkg::action_e'(w.action) == hlbbc_pkg::ACT_GET) begin
        bkt = 3'(w.block_number % NBKT);
        for (int i = 0; i < NBUF; i++)
          if (found < 0 && bkt_q[i] == bkt && dev_q[i] == w.device &&
              blk_q[i] == w.block_number)
            found = i;
        if (found >= 0) begin
          if (refs_q[found] != hlbbc_pkg::RefsMax) refs_q[found]++;
          r.hit = 1'b1;
          r.needs_fill = !vld_q[found];
          vld_q[found] = 1'b1;
          r.entry_index = 5'(found);
        end else begin
          v = oldest_free(1'b1, bkt);
          if (v < 0) v = oldest_free(1'b0, '0);
          if (v < 0) r.status = hlbbc_pkg::ST_NO_FREE;
          else begin
            dev_q[v] = w.device; blk_q[v] = w.block_number; bkt_q[v] = bkt;
            refs_q[v] = 8'd1; vld_q[v] = 1'b1;
            r.needs_fill = 1'b1;
            r.entry_index = 5'(v);
          end
        end
      end else begin
        r.entry_index = w.buffer_index;
        if (hlbbc_pkg::action_e'(w.action) == hlbbc_pkg::ACT_PIN) begin
          if (refs_q[w.buffer_index] != hlbbc_pkg::RefsMax) refs_q[w.buffer_index]++;
        end else if (refs_q[w.buffer_index] == 0) begin
          r.status = hlbbc_pkg::ST_UNDERFLOW;
        end else begin
          refs_q[w.buffer_index]--;
          if (hlbbc_pkg::action_e'(w.action) == hlbbc_pkg::ACT_RELEASE &&
              refs_q[w.buffer_index] == 0)
            stamp_q[w.buffer_index] = w.current_time;
        end
      end
      pending_rsp.push_back(r);
    endfunction

    function void check_word(hlbbc_pkg::rsp_t got);
      hlbbc_pkg::rsp_t exp_w;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp_w = pending_rsp.pop_front();
      if (got.entry_index !== exp_w.entry_index || got.hit !== exp_w.hit ||
          got.needs_fill !== exp_w.needs_fill || got.status !== exp_w.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp idx=%0d hit=%b fill=%b st=%0d, %s",
                   exp_w.entry_index, exp_w.hit, exp_w.needs_fill, exp_w.status,
                   $sformatf("got idx=%0d hit=%b fill=%b st=%0d",
                             got.entry_index, got.hit, got.needs_fill, got.status));
      end
    endfunction
  endclass

  cache_scoreboard sb = new();

  int send_idle_pct = 19;
  int recv_idle_pct = 49;
  int idle_cycles = 0;
  logic [31:0] tick = 32'd1;

  // Sample on the edge; accepted words go to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && req_valid_i && !req_stall_o) sb.note_word(req_i);
    if (rst_ni && rsp_valid_o && !rsp_stall_i) sb.check_word(rsp_o);
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    rsp_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: nothing moving for too long means the block is stuck.
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Drive one word, with a random gap beforehand; returns at the accepting
  // edge with valid still high, the next send or drain takes it down.
  task automatic send_word(hlbbc_pkg::req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
  endtask

  task automatic send_op(hlbbc_pkg::action_e a, logic [7:0] d, logic [31:0] b,
                         logic [4:0] idx, logic [31:0] t);
    hlbbc_pkg::req_t w;
    w.action = a; w.device = d; w.block_number = b; w.buffer_index = idx;
    w.current_time = t;
    send_word(w);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // Random well-formed traffic: gets on a small block set so hits recur,
  // releases/pins/unpins on random entries, plus occasional wide noise.
  task automatic random_word();
    int sel;
    logic [31:0] blk;
    logic [4:0] idx;
    sel = $urandom_range(99);
    tick = tick + $urandom_range(3);
    blk = $urandom_range(40);
    if ($urandom_range(9) == 0) blk = $urandom();
    idx = 5'($urandom_range(NBUF - 1));
    if (sel < 45)
      send_op(hlbbc_pkg::ACT_GET,
              8'($urandom_range(2)) | (($urandom_range(19) == 0) ? 8'hff : 8'h0),
              blk, 5'($urandom()), $urandom());
    else if (sel < 80)
      send_op(hlbbc_pkg::ACT_RELEASE, 8'($urandom()), $urandom(), idx,
              ($urandom_range(19) == 0) ? $urandom() : tick);
    else if (sel < 90)
      send_op(hlbbc_pkg::ACT_PIN, 8'($urandom()), $urandom(), idx, $urandom());
    else
      send_op(hlbbc_pkg::ACT_UNPIN, 8'($urandom()), $urandom(), idx, $urandom());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset-state hit on device 0 block 0, misses, extremes.
    send_op(hlbbc_pkg::ACT_GET, 8'h00, 32'h0, 5'd0, 32'h0);
    send_op(hlbbc_pkg::ACT_GET, 8'hff, 32'hffffffff, 5'd31, 32'hffffffff);
    send_op(hlbbc_pkg::ACT_GET, 8'hff, 32'hffffffff, 5'd0, 32'h0);
    send_op(hlbbc_pkg::ACT_RELEASE, 8'h0, 32'h0, 5'd0, 32'hffffffff);
    send_op(hlbbc_pkg::ACT_RELEASE, 8'h0, 32'h0, 5'd0, 32'h5);     // underflow
    send_op(hlbbc_pkg::ACT_UNPIN, 8'h0, 32'h0, 5'd31, 32'h0);      // underflow
    send_op(hlbbc_pkg::ACT_PIN, 8'h0, 32'h0, 5'd31, 32'h0);
    send_op(hlbbc_pkg::ACT_UNPIN, 8'h0, 32'h0, 5'd31, 32'h0);      // to zero, no stamp
    // Same bucket exhausted: spills to the oldest free entry of the pool.
    for (int i = 0; i < 6; i++)
      send_op(hlbbc_pkg::ACT_GET, 8'h7, 32'(8 * i + 3), 5'd0, 32'h0);
    // Saturate a count, then fill the pool until no entry is free.
    for (int i = 0; i < 260; i++) send_op(hlbbc_pkg::ACT_PIN, 8'h0, 32'h0, 5'd9, 32'h0);
    for (int i = 0; i < 34; i++)
      send_op(hlbbc_pkg::ACT_GET, 8'h55, 32'(1000 + i), 5'd0, 32'h0);
    drain();
    for (int i = 0; i < NBUF; i++)
      send_op(hlbbc_pkg::ACT_RELEASE, 8'h0, 32'h0, 5'(i), 32'(NBUF - i));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < 200; n++) begin
        random_word();
        if (n == 100) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
